FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the Base64 encoder.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define B64_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define B64_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/b64enc_pkg.sv
// Types, constants and the character map of the Base64 stream encoder.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] GRP_EMPTY = 2'd0;
    localparam logic [1:0] GRP_ONE   = 2'd1;
    localparam logic [1:0] GRP_TWO   = 2'd2;
    localparam logic [1:0] GRP_FULL  = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] cnt;
        logic       last;
    } t_group;

    typedef struct packed {
        logic   push;
        t_group grp;
    } t_grp_wr;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'd65 + w;
        end else if (v < 6'd52) begin
            return 8'd71 + w;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return 8'd43;
        end else begin
            return 8'd47;
        end
    endfunction

endpackage

FILE: src/base64_stream_encoder_core.sv
// Top level of the Base64 stream encoder: front end, group queue, back end.
// Uses b64enc_pkg, b64enc_front, b64enc_queue and b64enc_back.
`timescale 1ns / 1ps

// Bytes are taken one per cycle while full is low; every third byte, or a
// byte flagged last, closes a group that enters a four-deep queue. The back
// end turns one group into four characters at one character per cycle while
// pop keeps up, so the sustained rate is set by the result port, with full
// rising only when the queue backs up. With the back end idle, the byte
// closing a group is written into the queue, the group is then loaded into
// the back-end group register, and its first character then enters the
// output register on the result ports. A flagged byte ending a partial group
// gives '=' padding, and the fourth character of that group carries last_char.

module base64_stream_encoder_core
    import b64enc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    t_grp_wr grp_wr;
    t_group  q_grp;
    logic    q_valid;
    logic    q_pop;
    logic    accept;

    assign accept = push && !full;

    b64enc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_item (i_in_item),
        .o_grp_wr  (grp_wr)
    );

    b64enc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_grp_wr (grp_wr),
        .i_pop    (q_pop),
        .o_full   (full),
        .o_valid  (q_valid),
        .o_grp    (q_grp)
    );

    b64enc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_grp    (q_grp),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_item (o_out_item)
    );

endmodule

FILE: src/b64enc_front.sv
// Front end: collects accepted bytes into groups of up to three and
// hands each closed group to the queue. Uses b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_front
    import b64enc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_in_item,
    output t_grp_wr  o_grp_wr
);

    logic [15:0] r_held, n_held;
    logic [1:0]  r_cnt, n_cnt;
    logic [7:0]  b0, b1, b2;
    logic [1:0]  cnt_inc;
    logic        close;

    always_comb begin
        b0 = r_held[15:8];
        b1 = 8'd0;
        b2 = 8'd0;
        unique case (r_cnt)
            GRP_EMPTY: b0 = i_in_item.data_byte;
            GRP_ONE:   b1 = i_in_item.data_byte;
            GRP_TWO: begin
                b1 = r_held[7:0];
                b2 = i_in_item.data_byte;
            end
            default: b0 = i_in_item.data_byte;
        endcase
        cnt_inc = (r_cnt == GRP_TWO) ? GRP_FULL :
                  (r_cnt == GRP_ONE) ? GRP_TWO  : GRP_ONE;
        close   = (cnt_inc == GRP_FULL) || i_in_item.last_byte;

        n_held = r_held;
        n_cnt  = r_cnt;
        if (i_accept) begin
            n_held = close ? 16'd0 : {b0, b1};
            n_cnt  = close ? GRP_EMPTY : cnt_inc;
        end

        o_grp_wr.push     = i_accept && close;
        o_grp_wr.grp.b0   = b0;
        o_grp_wr.grp.b1   = b1;
        o_grp_wr.grp.b2   = b2;
        o_grp_wr.grp.cnt  = cnt_inc;
        o_grp_wr.grp.last = i_in_item.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 16'd0;
            r_cnt  <= GRP_EMPTY;
        end else begin
            r_held <= n_held;
            r_cnt  <= n_cnt;
        end
    end

endmodule

FILE: src/b64enc_queue.sv
// Short queue of closed byte groups between front and back end.
// Uses b64enc_pkg for the group type and the queue depth.
`timescale 1ns / 1ps

module b64enc_queue
    import b64enc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_grp_wr i_grp_wr,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_group  o_grp
);

    t_group          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr, r_rptr;
    logic [Q_AW:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_grp   = r_mem[r_rptr];
    assign do_push = i_grp_wr.push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_grp_wr.grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: src/b64enc_back.sv
// Back end: takes one group at a time from the queue and sends its four
// characters, one per cycle while pop keeps up, through an output register. Uses b64enc_pkg.
`timescale 1ns / 1ps

module b64enc_back
    import b64enc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_group    i_q_grp,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out_item
);

    t_group     r_grp;
    logic       r_grp_vld;
    logic [1:0] r_idx;
    t_out_item  r_out;
    logic       r_out_vld;
    logic       advance;
    logic       load;
    logic [5:0] sextet;
    logic       pad;
    t_out_item  ch;

    assign advance = r_grp_vld && (!r_out_vld || i_pop);
    assign load    = !r_grp_vld || (advance && (r_idx == 2'd3));
    assign o_q_pop = load && i_q_valid;

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.b0[7:2];
            2'd1:    sextet = {r_grp.b0[1:0], r_grp.b1[7:4]};
            2'd2:    sextet = {r_grp.b1[3:0], r_grp.b2[7:6]};
            default: sextet = r_grp.b2[5:0];
        endcase
        pad = ((r_idx == 2'd2) && (r_grp.cnt == GRP_ONE)) ||
              ((r_idx == 2'd3) && (r_grp.cnt != GRP_FULL));
        ch.out_char  = pad ? PAD_CHAR : b64_char(sextet);
        ch.last_char = (r_idx == 2'd3) && r_grp.last;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_grp <= i_q_grp;
        end
        if (advance) begin
            r_out <= ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_vld <= 1'b0;
            r_idx     <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_grp_vld <= i_q_valid;
                r_idx     <= 2'd0;
            end else if (advance) begin
                r_idx <= r_idx + 2'd1;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_vld;
    assign o_out_item = r_out;

endmodule

FILE: src/b64enc_checker.sv
// Port-level checks of the Base64 stream encoder, bound to its top level.
// Uses b64enc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64enc_checker
    import b64enc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    logic stalled;
    logic pad_pop;
    logic final_pad;

    assign stalled   = !empty && !pop;
    assign pad_pop   = pop && !empty && (o_out_item.out_char == PAD_CHAR) &&
                       !o_out_item.last_char;
    assign final_pad = (o_out_item.out_char == PAD_CHAR) && o_out_item.last_char;

    `B64_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (empty && !full), "reset not clean")

    `B64_ASSERT(a_hold, i_clk, i_rst_n, stalled |=> !empty && $stable(o_out_item), "item changed")

    `B64_ASSERT(a_pad_pair, i_clk, i_rst_n, pad_pop |=> !empty && final_pad, "pad out of order")

endmodule

bind base64_stream_encoder_core b64enc_checker u_chk (.*);

FILE: verif/tb_base64_stream_encoder_core.sv
// Self-checking testbench for base64_stream_encoder_core: directed table, then random messages.
// Depends on b64enc_pkg for the item types and the pad code; predicts untyped characters in-line.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;
    import b64enc_pkg::*;

    localparam int N_RANDOM_BYTES = 500;
    localparam int N_DIRECTED     = 22;
    localparam int CALM_TAIL      = 80;
    localparam int LONG_HOLD      = 200;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic [511:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      full;
    t_in_item  in_item = '0;
    logic      empty;
    logic      pop     = 1'b0;
    t_out_item out_item;

    t_out_item  char_fifo[$];
    logic [15:0] held_q  = '0;
    logic [1:0]  held_cnt = GRP_EMPTY;
    int          err_cnt  = 0;
    int          cycle_cnt = 0;
    bit          calm      = 1'b0;
    bit          stall_req = 1'b0;

    // {data_byte, last_byte, typed characters or zero for predicted}
    logic [40:0] dir_rows [N_DIRECTED] = '{
        {8'h00, 1'b1, "AA=="},
        {8'hFF, 1'b1, "/w=="},
        {8'hFF, 1'b0, 32'd0},
        {8'hFF, 1'b1, "//8="},
        {8'hFF, 1'b0, 32'd0},
        {8'hFF, 1'b0, 32'd0},
        {8'hFF, 1'b1, "////"},
        {8'h4D, 1'b0, 32'd0},
        {8'h61, 1'b0, 32'd0},
        {8'h6E, 1'b1, "TWFu"},
        {8'h4D, 1'b0, 32'd0},
        {8'h61, 1'b1, "TWE="},
        {8'h4D, 1'b1, "TQ=="},
        {8'hFB, 1'b0, 32'd0},
        {8'hEF, 1'b0, 32'd0},
        {8'hBE, 1'b0, "++++"},
        {8'h00, 1'b0, 32'd0},
        {8'h00, 1'b0, 32'd0},
        {8'h00, 1'b0, "AAAA"},
        {8'h12, 1'b1, 32'd0},
        {8'h34, 1'b0, 32'd0},
        {8'h56, 1'b1, 32'd0}
    };

    base64_stream_encoder_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
        return B64_ALPHABET[8 * (63 - v) +: 8];
    endfunction

    task automatic encode_byte(input logic [7:0] b, input logic l, input logic [31:0] typed);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [1:0]  cnt;
        logic [31:0] chars;
        t_out_item   tmp;
        cnt = (held_cnt == GRP_FULL) ? GRP_EMPTY : held_cnt;
        b0 = (cnt == GRP_EMPTY) ? b : held_q[15:8];
        b1 = (cnt == GRP_ONE) ? b : ((cnt == GRP_TWO) ? held_q[7:0] : 8'h00);
        b2 = (cnt == GRP_TWO) ? b : 8'h00;
        cnt = cnt + 2'd1;
        chars = {sextet_ascii(b0[7:2]), sextet_ascii({b0[1:0], b1[7:4]}),
                 sextet_ascii({b1[3:0], b2[7:6]}), sextet_ascii(b2[5:0])};
        if (cnt != GRP_FULL && !l) begin
            held_q   = {b0, b1};
            held_cnt = cnt;
            return;
        end
        if (cnt != GRP_FULL) begin
            if (cnt == GRP_ONE) chars[15:8] = PAD_CHAR;
            chars[7:0] = PAD_CHAR;
        end
        if (typed != 32'd0) chars = typed;
        for (int k = 0; k < 4; k++) begin
            tmp.out_char  = chars[31 - 8 * k -: 8];
            tmp.last_char = (k == 3) ? l : 1'b0;
            char_fifo.push_back(tmp);
        end
        held_q   = '0;
        held_cnt = GRP_EMPTY;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l, input logic [31:0] typed);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push              <= 1'b1;
        in_item.data_byte <= b;
        in_item.last_byte <= l;
        do @(posedge i_clk); while (full);
        encode_byte(b, l, typed);
    endtask

    initial begin
        int sent;
        int len;
        logic [7:0] b;
        sent = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_byte(dir_rows[r][40:33], dir_rows[r][32], dir_rows[r][31:0]);
        end
        stall_req = 1'b1;
        while (sent < N_RANDOM_BYTES) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                send_byte(b, k == len - 1, 32'd0);
                sent++;
                if (N_RANDOM_BYTES - sent < CALM_TAIL) calm = 1'b1;
            end
        end
        calm = 1'b1;
        @(negedge i_clk);
        push <= 1'b0;
        while (char_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && char_fifo.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(negedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                hold_cnt  = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_cnt = $urandom_range(1, 5) - 1;
                pop <= 1'b0;
            end else begin
                pop <= i_rst_n;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (char_fifo.size() == 0) begin
                $display("%0t: unexpected char %h last %b, expected none",
                         $time, out_item.out_char, out_item.last_char);
                err_cnt++;
            end else begin
                want = char_fifo.pop_front();
                if (out_item.out_char !== want.out_char) begin
                    $display("%0t: out_char expected %h, actual %h",
                             $time, want.out_char, out_item.out_char);
                    err_cnt++;
                end
                if (out_item.last_char !== want.last_char) begin
                    $display("%0t: last_char expected %b, actual %b",
                             $time, want.last_char, out_item.last_char);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder_core.sv
src/b64enc_checker.sv
verif/tb_base64_stream_encoder_core.sv
